[rtl/cbd_pkg.sv]
// Shared types and constants for the chunked body decoder.
// No dependencies; imported by cbd_parser and chunked_body_decoder.
`timescale 1ns / 1ps

package cbd_pkg;

   typedef enum logic [1:0] {
      PH_SIZE = 2'd0,
      PH_DATA = 2'd1,
      PH_SKIP = 2'd2,
      PH_DONE = 2'd3
   } phase_type;

   localparam int unsigned CRLF_LEN = 2;

   localparam logic [7:0] CH_HT    = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;

   typedef struct packed {
      logic       valid;
      logic [7:0] data_byte;
      logic       has_data;
      logic       body_done;
      logic       size_overflow;
   } result_type;

   typedef struct packed {
      logic       is_hex;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      logic [7:0] off;
      h   = '{is_hex: 1'b0, value: 4'd0};
      off = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         off = c - CH_ZERO;
         h   = '{is_hex: 1'b1, value: off[3:0]};
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         off = c - CH_UP_A + 8'd10;
         h   = '{is_hex: 1'b1, value: off[3:0]};
      end else if (c >= CH_LO_A && c <= CH_LO_F) begin
         off = c - CH_LO_A + 8'd10;
         h   = '{is_hex: 1'b1, value: off[3:0]};
      end
      return h;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_HT && c <= CH_CR);
   endfunction

endpackage

[rtl/cbd_parser.sv]
// Parser state and step logic for the chunked body decoder.
// Depends on cbd_pkg for the phase enum, character codes and result struct.
`timescale 1ns / 1ps

module cbd_parser
   import cbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] body_byte,
   input  logic       start_of_body,
   output result_type result
);

   phase_type            phase_ff, phase_in;
   logic [SIZE_BITS-1:0] accum_ff, accum_in;
   logic [SIZE_BITS-1:0] left_ff, left_in;
   logic                 closed_ff, closed_in;
   logic                 seen_ff, seen_in;
   logic                 ovf_ff, ovf_in;

   // State as seen by this byte: a start flag clears it first.
   phase_type            cur_phase;
   logic [SIZE_BITS-1:0] cur_accum;
   logic [SIZE_BITS-1:0] cur_left;
   logic                 cur_closed;
   logic                 cur_seen;
   logic                 cur_ovf;

   hex_type              hex;
   logic                 saturate;
   logic [SIZE_BITS-1:0] left_dec;
   logic                 size_end;

   always_comb begin
      if (start_of_body) begin
         cur_phase  = PH_SIZE;
         cur_accum  = '0;
         cur_left   = '0;
         cur_closed = 1'b0;
         cur_seen   = 1'b0;
         cur_ovf    = 1'b0;
      end else begin
         cur_phase  = phase_ff;
         cur_accum  = accum_ff;
         cur_left   = left_ff;
         cur_closed = closed_ff;
         cur_seen   = seen_ff;
         cur_ovf    = ovf_ff;
      end
   end

   assign hex      = hex_decode(body_byte);
   // Shifting in another digit overflows when any of the top nibble is set.
   assign saturate = |cur_accum[SIZE_BITS-1 -: 4];
   assign left_dec = cur_left - SIZE_BITS'(1);
   assign size_end = !cur_seen || (cur_accum == '0);

   // Next state.
   always_comb begin
      phase_in  = cur_phase;
      accum_in  = cur_accum;
      left_in   = cur_left;
      closed_in = cur_closed;
      seen_in   = cur_seen;
      ovf_in    = cur_ovf;
      unique case (cur_phase)
         PH_SIZE: begin
            if (body_byte == CH_LF) begin
               if (size_end) begin
                  phase_in = PH_DONE;
               end else begin
                  phase_in = PH_DATA;
                  left_in  = cur_accum;
               end
            end else if (!cur_closed) begin
               if (hex.is_hex) begin
                  seen_in = 1'b1;
                  if (saturate) begin
                     accum_in = '1;
                     ovf_in   = 1'b1;
                  end else begin
                     accum_in = {cur_accum[SIZE_BITS-5:0], hex.value};
                  end
               end else if (cur_seen || !is_space(body_byte)) begin
                  closed_in = 1'b1;
               end
            end
         end
         PH_DATA: begin
            if (left_dec == '0) begin
               phase_in = PH_SKIP;
               left_in  = SIZE_BITS'(CRLF_LEN);
            end else begin
               left_in = left_dec;
            end
         end
         PH_SKIP: begin
            if (cur_left != '0) begin
               left_in = left_dec;
            end
            if (cur_left <= SIZE_BITS'(1)) begin
               phase_in  = PH_SIZE;
               accum_in  = '0;
               closed_in = 1'b0;
               seen_in   = 1'b0;
               ovf_in    = 1'b0;
            end
         end
         PH_DONE: begin
            phase_in = PH_DONE;
         end
         default: begin
            phase_in = PH_SIZE;
         end
      endcase
   end

   // Result for this byte.
   always_comb begin
      result = '{valid: 1'b0, data_byte: 8'd0, has_data: 1'b0,
                 body_done: 1'b0, size_overflow: 1'b0};
      unique case (cur_phase)
         PH_SIZE: begin
            if (body_byte == CH_LF && size_end) begin
               result.valid         = 1'b1;
               result.body_done     = 1'b1;
               result.size_overflow = cur_ovf;
            end
         end
         PH_DATA: begin
            result.valid         = 1'b1;
            result.data_byte     = body_byte;
            result.has_data      = 1'b1;
            result.size_overflow = cur_ovf;
         end
         PH_SKIP, PH_DONE: begin
            result.valid = 1'b0;
         end
         default: begin
            result.valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SIZE;
         accum_ff  <= '0;
         left_ff   <= '0;
         closed_ff <= 1'b0;
         seen_ff   <= 1'b0;
         ovf_ff    <= 1'b0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         accum_ff  <= accum_in;
         left_ff   <= left_in;
         closed_ff <= closed_in;
         seen_ff   <= seen_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule

[rtl/chunked_body_decoder.sv]
// Top level of the chunked transfer body decoder: input register, parser, result register.
// Depends on cbd_pkg and cbd_parser.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  body_byte[7:0], start_of_body
//   rsp_      out        rsp_valid/rsp_stall  data_byte[7:0], has_data, body_done,
//                                             size_overflow
//
// One byte per clock sustained while rsp_stall is low. A byte moves from the input
// register through the parser to the result register; the parser state steps with it.
// Bytes that give no result (size line, CRLF, after done) are consumed silently.
// Reset is synchronous and active high; it clears the parser and the valid flags of both registers.
// A stall on rsp_ holds the result register and backs up into req_stall only
// once the input register is also full.
`timescale 1ns / 1ps

module chunked_body_decoder
   import cbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_body_byte,
   input  logic       req_start_of_body,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_has_data,
   output logic       rsp_body_done,
   output logic       rsp_size_overflow
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;

   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;
   logic       rsp_has_data_ff;
   logic       rsp_done_ff;
   logic       rsp_ovf_ff;

   logic       advance;
   logic       req_take;
   result_type result;

   // The held byte moves on whenever the result register is free or draining.
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_body_byte;
         in_start_ff <= req_start_of_body;
      end
   end

   cbd_parser #(
      .SIZE_BITS(SIZE_BITS)
   ) u_parser (
      .clock        (clock),
      .reset        (reset),
      .step_en      (advance),
      .body_byte    (in_byte_ff),
      .start_of_body(in_start_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= result.valid;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         rsp_data_ff     <= result.data_byte;
         rsp_has_data_ff <= result.has_data;
         rsp_done_ff     <= result.body_done;
         rsp_ovf_ff      <= result.size_overflow;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data_byte     = rsp_data_ff;
   assign rsp_has_data      = rsp_has_data_ff;
   assign rsp_body_done     = rsp_done_ff;
   assign rsp_size_overflow = rsp_ovf_ff;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff)
      else $error("req_stall raised with an empty input register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("parser stepped while the result register was stalled");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("a held input transaction was dropped");

   a_result_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $onehot({rsp_has_data_ff, rsp_done_ff}))
      else $error("result is neither a single data byte nor a done marker");

endmodule

[bench/chunked_body_decoder_tb.sv]
// Self-checking bench for chunked_body_decoder: streams chunked bodies, predicts the
// decoded payload and end-of-body results, and compares them on the rsp_ channel.
// Depends on cbd_pkg and the chunked_body_decoder RTL.
`timescale 1ns / 1ps

module chunked_body_decoder_tb
   import cbd_pkg::*;
;

   localparam int SIZE_BITS = 32;
   localparam logic [SIZE_BITS-1:0] SIZE_SAT = '1;
   localparam int TOTAL_BYTES = 530;
   localparam int HOLD_CYCLES = 60;
   localparam int FIRST_HOLD_AT = 150;
   localparam int SECOND_HOLD_AT = 420;
   localparam int NO_MORE_HOLDS = 32'h7FFF_FFFF;
   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT = 100000;

   localparam logic [7:0] CH_VT   = 8'h0B;
   localparam logic [7:0] CH_FF   = 8'h0C;
   localparam logic [7:0] CH_SEMI = 8'h3B;

   typedef struct {
      logic [7:0] value;
      logic       sob;
      logic       drain;
   } body_byte_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_data;
      logic       body_done;
      logic       size_overflow;
   } decoded_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_body_byte = 8'd0;
   logic       req_start_of_body = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_data_byte;
   logic       rsp_has_data;
   logic       rsp_body_done;
   logic       rsp_size_overflow;

   body_byte_type pending_bytes[$];
   decoded_type   expected_decoded[$];

   // Predicted parser state, at its reset values.
   phase_type            parse_phase = PH_SIZE;
   logic [SIZE_BITS-1:0] size_acc = '0;
   logic                 number_closed = 1'b0;
   logic                 got_digit = 1'b0;
   logic [SIZE_BITS-1:0] bytes_to_go = '0;
   logic                 saturated = 1'b0;

   int cycle_count = 0;
   int bytes_sent = 0;
   int bodies_started = 0;
   int payload_checked = 0;
   int oversized_checked = 0;
   int done_checked = 0;
   int errors = 0;
   int hold_left = 0;
   int hold_at = FIRST_HOLD_AT;

   chunked_body_decoder #(
      .SIZE_BITS(SIZE_BITS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_body_byte(req_body_byte),
      .req_start_of_body(req_start_of_body),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data_byte(rsp_data_byte),
      .rsp_has_data(rsp_has_data),
      .rsp_body_done(rsp_body_done),
      .rsp_size_overflow(rsp_size_overflow)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic idle_now();
      // A stretch of the run with back-to-back traffic on both sides.
      if (bytes_sent >= 250 && bytes_sent < 350) return 1'b0;
      return $urandom_range(0, 99) < 20;
   endfunction

   task automatic start_size_line();
      size_acc = '0;
      number_closed = 1'b0;
      got_digit = 1'b0;
      saturated = 1'b0;
   endtask

   task automatic decode_body_byte(input logic [7:0] b, input logic sob);
      decoded_type r;
      logic        is_digit;
      logic [3:0]  nib;
      r = '0;
      is_digit = 1'b1;
      nib = 4'd0;
      if (sob) begin
         parse_phase = PH_SIZE;
         bytes_to_go = '0;
         start_size_line();
      end
      case (parse_phase)
         PH_SIZE: begin
            if (b == CH_LF) begin
               if (!got_digit || size_acc == '0) begin
                  parse_phase = PH_DONE;
                  r.body_done = 1'b1;
                  r.size_overflow = saturated;
                  expected_decoded.push_back(r);
               end else begin
                  parse_phase = PH_DATA;
                  bytes_to_go = size_acc;
               end
            end else if (!number_closed) begin
               if (b >= CH_ZERO && b <= CH_NINE) nib = 4'(b - CH_ZERO);
               else if (b >= CH_UP_A && b <= CH_UP_F) nib = 4'(b - CH_UP_A + 8'd10);
               else if (b >= CH_LO_A && b <= CH_LO_F) nib = 4'(b - CH_LO_A + 8'd10);
               else is_digit = 1'b0;
               if (is_digit) begin
                  got_digit = 1'b1;
                  if (size_acc > (SIZE_SAT >> 4)) begin
                     size_acc = SIZE_SAT;
                     saturated = 1'b1;
                  end else begin
                     size_acc = {size_acc[SIZE_BITS-5:0], nib};
                  end
               end else if (got_digit || !(b == CH_SPACE || (b >= CH_HT && b <= CH_CR))) begin
                  number_closed = 1'b1;
               end
            end
         end
         PH_DATA: begin
            r.data_byte = b;
            r.has_data = 1'b1;
            r.size_overflow = saturated;
            expected_decoded.push_back(r);
            bytes_to_go--;
            if (bytes_to_go == '0) begin
               parse_phase = PH_SKIP;
               bytes_to_go = CRLF_LEN;
            end
         end
         PH_SKIP: begin
            if (bytes_to_go != '0) bytes_to_go--;
            if (bytes_to_go == '0) begin
               parse_phase = PH_SIZE;
               start_size_line();
            end
         end
         default: ;
      endcase
   endtask

   task automatic queue_byte(input logic [7:0] value, input logic sob = 1'b0);
      pending_bytes.push_back('{value: value, sob: sob, drain: 1'b0});
   endtask

   task automatic queue_string(input string s, input logic sob = 1'b0);
      for (int i = 0; i < s.len(); i++) queue_byte(s[i], sob && i == 0);
   endtask

   // Size line in hex with random case, optional leading whitespace, leading zero
   // and extension, and a CRLF or bare LF ending.
   task automatic queue_size_line(input logic [47:0] size, input logic sob, input logic drain);
      logic [7:0] ws_set [5] = '{CH_SPACE, CH_HT, CH_VT, CH_FF, CH_CR};
      int         first;
      int         nd;
      logic [3:0] nib;
      first = pending_bytes.size();
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
         queue_byte(ws_set[3'($urandom_range(0, 4))]);
      if ($urandom_range(0, 3) == 0) queue_byte(CH_ZERO);
      nd = 1;
      while (nd < 12 && (size >> (4 * nd)) != 0) nd++;
      for (int k = nd - 1; k >= 0; k--) begin
         nib = size[4 * k +: 4];
         if (nib < 4'd10) queue_byte(CH_ZERO + 8'(nib));
         else queue_byte(($urandom_range(0, 1) ? CH_UP_A : CH_LO_A) + 8'(nib) - 8'd10);
      end
      if ($urandom_range(0, 3) == 0) begin
         queue_byte(CH_SEMI);
         repeat ($urandom_range(0, 4)) queue_byte(8'($urandom_range(CH_VT, 8'hFF)));
      end
      if ($urandom_range(0, 3) != 0) queue_byte(CH_CR);
      queue_byte(CH_LF);
      pending_bytes[first].sob = sob;
      pending_bytes[first].drain = drain;
   endtask

   // Sender: offers queued bytes and runs each accepted transaction through the predictor.
   always @(posedge clock) begin
      logic fire;
      fire = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            decode_body_byte(req_body_byte, req_start_of_body);
            bytes_sent++;
            if (req_start_of_body) bodies_started++;
         end
         if (req_valid && !fire) begin
            // Stalled: the payload stays as it is.
         end else if (pending_bytes.size() != 0
                      && !(pending_bytes[0].drain && expected_decoded.size() != 0)
                      && !idle_now()) begin
            req_valid <= 1'b1;
            req_body_byte <= pending_bytes[0].value;
            req_start_of_body <= pending_bytes[0].sob;
            pending_bytes.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: checks each accepted result and drives the stall, with two long holds.
   always @(posedge clock) begin
      decoded_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_decoded.size() == 0) begin
               $error("unexpected result: data_byte %02h has_data %b body_done %b size_overflow %b",
                      rsp_data_byte, rsp_has_data, rsp_body_done, rsp_size_overflow);
               errors++;
            end else begin
               want = expected_decoded.pop_front();
               if (rsp_data_byte !== want.data_byte) begin
                  $error("data_byte: expected %02h, actual %02h", want.data_byte, rsp_data_byte);
                  errors++;
               end
               if (rsp_has_data !== want.has_data) begin
                  $error("has_data: expected %b, actual %b", want.has_data, rsp_has_data);
                  errors++;
               end
               if (rsp_body_done !== want.body_done) begin
                  $error("body_done: expected %b, actual %b", want.body_done, rsp_body_done);
                  errors++;
               end
               if (rsp_size_overflow !== want.size_overflow) begin
                  $error("size_overflow: expected %b, actual %b",
                         want.size_overflow, rsp_size_overflow);
                  errors++;
               end
               if (want.has_data) payload_checked++;
               if (want.body_done) done_checked++;
               if (want.size_overflow) oversized_checked++;
            end
         end
         if (hold_left != 0) begin
            hold_left--;
         end else if (bytes_sent >= hold_at) begin
            hold_left = HOLD_CYCLES;
            hold_at = (hold_at == FIRST_HOLD_AT) ? SECOND_HOLD_AT : NO_MORE_HOLDS;
         end
         rsp_stall <= (hold_left != 0) || idle_now();
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int          shape;
      int          nchunks;
      int          size;
      int          count;
      int          built;
      logic        first_drain;
      logic        ended;
      logic [47:0] big;

      // Leading HT and CR skipped, extension with a hex letter ignored, one 0xFF
      // data byte, an LF among the two dropped bytes, then the zero-size line.
      queue_byte(CH_HT, 1'b1);
      queue_byte(CH_CR);
      queue_string("1;a");
      queue_byte(CH_CR);
      queue_byte(CH_LF);
      queue_byte(8'hFF);
      queue_byte(8'h00);
      queue_byte(CH_LF);
      queue_string("0\n");
      // Ignored after the body has ended.
      queue_byte(8'hFF);
      // VT, FF and space skipped, then a line with no digit ends the body.
      queue_byte(CH_VT, 1'b1);
      queue_byte(CH_FF);
      queue_string(" g\n");
      // A 0x prefix is not understood: the size is zero and the 5 is ignored.
      queue_string("0x5\n", 1'b1);
      // Nine hex digits saturate the size; the data bytes carry the flag.
      queue_string("fFFFFFFFf\n", 1'b1);
      queue_byte(8'h00);
      queue_byte(8'h80);

      built = 0;
      while (pending_bytes.size() < TOTAL_BYTES) begin
         shape = $urandom_range(0, 9);
         first_drain = (built == 0) || ($urandom_range(0, 3) == 0);
         ended = 1'b0;
         if (shape == 0) begin
            // Noise, possibly landing on a finished body.
            count = pending_bytes.size();
            repeat ($urandom_range(2, 10)) queue_byte(8'($urandom_range(0, 255)));
            pending_bytes[count].sob = 1'($urandom_range(0, 1));
            pending_bytes[count].drain = first_drain;
         end else begin
            nchunks = $urandom_range(1, 4);
            for (int c = 0; c < nchunks && !ended; c++) begin
               count = $urandom_range(0, 99);
               size = (count < 88) ? $urandom_range(1, 20) :
                      (count < 98) ? $urandom_range(21, 120) : $urandom_range(121, 400);
               if (shape == 1 && c == nchunks - 1) begin
                  // Oversized chunk, abandoned by the next body's start flag.
                  big = {16'($urandom_range(1, 16'hFFFF)), 32'($urandom)};
                  queue_size_line(big, c == 0, first_drain && c == 0);
                  repeat ($urandom_range(1, 6)) queue_byte(8'($urandom_range(0, 255)));
                  ended = 1'b1;
               end else begin
                  queue_size_line(48'(size), c == 0, first_drain && c == 0);
                  if (shape == 2 && c == nchunks - 1) begin
                     repeat ($urandom_range(0, size - 1))
                        queue_byte(8'($urandom_range(0, 255)));
                     ended = 1'b1;
                  end else begin
                     repeat (size) queue_byte(8'($urandom_range(0, 255)));
                     if ($urandom_range(0, 4) != 0) begin
                        queue_byte(CH_CR);
                        queue_byte(CH_LF);
                     end else begin
                        repeat (2) queue_byte(8'($urandom_range(0, 255)));
                     end
                  end
               end
            end
            if (!ended) begin
               case ($urandom_range(0, 3))
                  0, 1: queue_size_line(48'd0, 1'b0, 1'b0);
                  2: queue_byte(CH_LF);
                  default: begin
                     queue_byte(CH_SEMI);
                     queue_byte(CH_LF);
                  end
               endcase
               if ($urandom_range(0, 2) == 0)
                  repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
            end
         end
         built++;
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid || expected_decoded.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("tb: %0d bytes sent across %0d bodies, including noise and cut-off bodies",
               bytes_sent, bodies_started);
      $display("tb: checked %0d payload bytes (%0d with saturated size) and %0d body ends",
               payload_checked, oversized_checked, done_checked);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
